// ===== hw/rtl/eftb_pkg.sv =====
`timescale 1ns / 1ps
// eftb_pkg: shared types, constants and helpers for the ept fault table builder
// no dependencies; imported by eftb_ctrl, eftb_datapath and ept_fault_table_builder

package eftb_pkg;

  localparam int unsigned POOL_PAGES_DEF   = 64;
  localparam int unsigned ENTRIES_PER_PAGE = 512;
  localparam int unsigned IDX_W            = 9;
  localparam int unsigned ENTRY_W          = 64;
  localparam int unsigned GPA_W            = 48;
  localparam int unsigned PAGE_CNT_W       = 6;
  localparam int unsigned FRAME_LSB        = 12;
  localparam int unsigned FRAME_MSB        = 47;
  localparam int unsigned FRAME_W          = FRAME_MSB - FRAME_LSB + 1;

  localparam logic [PAGE_CNT_W-1:0] PAGE_LIMIT_RESET = 6'd50;
  localparam logic [ENTRY_W-1:0]    NONLEAF_BITS     = 64'h7;
  localparam logic [ENTRY_W-1:0]    LEAF_BITS        = 64'h37;

  localparam logic [1:0] LAST_LEVEL = 2'd3;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_FAULT  = 1'b1;

  localparam logic [2:0] ST_BUILT       = 3'd0;
  localparam logic [2:0] ST_PRESENT     = 3'd1;
  localparam logic [2:0] ST_NOT_MISSING = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED   = 3'd3;
  localparam logic [2:0] ST_HIT         = 3'd4;
  localparam logic [2:0] ST_MISS        = 3'd5;

  typedef enum logic [1:0] {
    LEAF_ZERO  = 2'd0,
    LEAF_READ  = 2'd1,
    LEAF_BUILT = 2'd2
  } leaf_src_e;

  typedef struct packed {
    logic             cmd;
    logic [GPA_W-1:0] fault_address;
    logic             fault_read;
    logic             fault_write;
    logic             fault_exec;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [ENTRY_W-1:0] leaf_entry;
    logic               flush_request;
  } result_t;

  typedef struct packed {
    logic       clr_wr;
    logic       load;
    logic       follow;
    logic       alloc;
    logic       write_leaf;
    logic       finish;
    leaf_src_e  res_src;
    logic [2:0] res_status;
  } ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic is_fault;
    logic any_access;
    logic last_level;
    logic entry_zero;
    logic next_ok;
    logic alloc_ok;
  } stat_t;

  // table index for one level of the walk
  function automatic logic [IDX_W-1:0] level_index(input logic [GPA_W-1:0] addr,
                                                   input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      2'd0:    idx = addr[47:39];
      2'd1:    idx = addr[38:30];
      2'd2:    idx = addr[29:21];
      default: idx = addr[20:12];
    endcase
    return idx;
  endfunction

endpackage

// ===== hw/rtl/eftb_ctrl.sv =====
`timescale 1ns / 1ps
// eftb_ctrl: controller state machine for the table walk, clear sweep and build
// depends on eftb_pkg; drives eftb_datapath through ctrl_t, reads back stat_t

module eftb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  eftb_pkg::stat_t stat_i,
  output eftb_pkg::ctrl_t ctrl_o,
  output logic           done_o
);
  import eftb_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    ctrl_o  = '0;
    unique case (state_q)
      S_CLEAR: begin
        ctrl_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctrl_o.load = 1'b1;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        if (stat_i.is_fault && stat_i.any_access) begin
          ctrl_o.finish     = 1'b1;
          ctrl_o.res_status = ST_NOT_MISSING;
          done_d            = 1'b1;
          state_d           = S_IDLE;
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_IDLE;
        priority if (stat_i.last_level) begin
          ctrl_o.finish = 1'b1;
          done_d        = 1'b1;
          priority if (!stat_i.entry_zero) begin
            ctrl_o.res_src    = LEAF_READ;
            ctrl_o.res_status = stat_i.is_fault ? ST_PRESENT : ST_HIT;
          end else if (stat_i.is_fault) begin
            ctrl_o.write_leaf = 1'b1;
            ctrl_o.res_src    = LEAF_BUILT;
            ctrl_o.res_status = ST_BUILT;
          end else begin
            ctrl_o.res_status = ST_MISS;
          end
        end else if (stat_i.is_fault && stat_i.entry_zero && stat_i.alloc_ok) begin
          ctrl_o.alloc = 1'b1;
          state_d      = S_READ;
        end else if (stat_i.next_ok) begin
          ctrl_o.follow = 1'b1;
          state_d       = S_READ;
        end else begin
          ctrl_o.finish     = 1'b1;
          ctrl_o.res_status = stat_i.is_fault ? ST_EXHAUSTED : ST_MISS;
          done_d            = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== hw/rtl/eftb_datapath.sv =====
`timescale 1ns / 1ps
// eftb_datapath: table memory, walk registers, page pool counter and result register
// depends on eftb_pkg; commanded by eftb_ctrl through ctrl_t

module eftb_datapath #(
  parameter int unsigned POOL_PAGES = eftb_pkg::POOL_PAGES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  eftb_pkg::req_t                     req_i,
  input  logic                               cfg_we_i,
  input  logic [eftb_pkg::PAGE_CNT_W-1:0]    cfg_wdata_i,
  input  eftb_pkg::ctrl_t                    ctrl_i,
  output eftb_pkg::stat_t                    stat_o,
  output eftb_pkg::result_t                  result_o
);
  import eftb_pkg::*;

  localparam int unsigned PAGE_W = $clog2(POOL_PAGES);
  localparam int unsigned MEM_AW = PAGE_W + IDX_W;
  localparam int unsigned DEPTH  = POOL_PAGES * ENTRIES_PER_PAGE;
  localparam logic [MEM_AW-1:0] LAST_SLOT = MEM_AW'(DEPTH - 1);

  logic [ENTRY_W-1:0] table_mem [DEPTH];

  req_t                  req_q, req_d;
  logic [1:0]            lvl_q, lvl_d;
  logic [PAGE_W-1:0]     page_q, page_d;
  logic [ENTRY_W-1:0]    rdata_q;
  logic [PAGE_CNT_W-1:0] pages_used_q, pages_used_d;
  logic [PAGE_CNT_W-1:0] page_limit_q, page_limit_d;
  logic [MEM_AW-1:0]     clr_cnt_q, clr_cnt_d;
  result_t               res_q, res_d;

  logic [MEM_AW-1:0]     slot;
  logic [PAGE_CNT_W:0]   np_wide;
  logic [FRAME_W-1:0]    next_frame;
  logic [ENTRY_W-1:0]    leaf_word;
  logic [ENTRY_W-1:0]    nonleaf_word;
  logic                  wr_en;
  logic [MEM_AW-1:0]     waddr;
  logic [ENTRY_W-1:0]    wdata;

  assign slot         = {page_q, level_index(req_q.fault_address, lvl_q)};
  assign np_wide      = {1'b0, pages_used_q} + {{PAGE_CNT_W{1'b0}}, 1'b1};
  assign next_frame   = rdata_q[FRAME_MSB:FRAME_LSB];
  assign leaf_word    = {16'b0, req_q.fault_address[FRAME_MSB:FRAME_LSB], 12'b0} | LEAF_BITS;
  assign nonleaf_word = (ENTRY_W'(np_wide) << FRAME_LSB) | NONLEAF_BITS;

  always_comb begin
    stat_o.clr_last   = (clr_cnt_q == LAST_SLOT);
    stat_o.is_fault   = (req_q.cmd == CMD_FAULT);
    stat_o.any_access = req_q.fault_read | req_q.fault_write | req_q.fault_exec;
    stat_o.last_level = (lvl_q == LAST_LEVEL);
    stat_o.entry_zero = (rdata_q == '0);
    // a pointer beyond the pool is not followed: the walk ends as a miss, or as exhausted for a fault
    stat_o.next_ok    = (rdata_q != '0) && (next_frame < FRAME_W'(POOL_PAGES));
    stat_o.alloc_ok   = (pages_used_q < page_limit_q) && (32'(np_wide) < POOL_PAGES);
  end

  always_comb begin
    wr_en = ctrl_i.clr_wr | ctrl_i.alloc | ctrl_i.write_leaf;
    waddr = ctrl_i.clr_wr ? clr_cnt_q : slot;
    priority if (ctrl_i.clr_wr) begin
      wdata = '0;
    end else if (ctrl_i.alloc) begin
      wdata = nonleaf_word;
    end else begin
      wdata = leaf_word;
    end
  end

  always_comb begin
    req_d        = req_q;
    lvl_d        = lvl_q;
    page_d       = page_q;
    pages_used_d = pages_used_q;
    page_limit_d = cfg_we_i ? cfg_wdata_i : page_limit_q;
    clr_cnt_d    = ctrl_i.clr_wr ? clr_cnt_q + 1'b1 : clr_cnt_q;
    res_d        = res_q;
    priority if (ctrl_i.load) begin
      req_d  = req_i;
      lvl_d  = '0;
      page_d = '0;
    end else if (ctrl_i.alloc) begin
      lvl_d        = lvl_q + 1'b1;
      page_d       = PAGE_W'(np_wide);
      pages_used_d = np_wide[PAGE_CNT_W-1:0];
    end else if (ctrl_i.follow) begin
      lvl_d  = lvl_q + 1'b1;
      page_d = next_frame[PAGE_W-1:0];
    end else begin
      lvl_d = lvl_q;
    end
    if (ctrl_i.finish) begin
      res_d.status        = ctrl_i.res_status;
      res_d.flush_request = (ctrl_i.res_status == ST_BUILT);
      unique case (ctrl_i.res_src)
        LEAF_READ:  res_d.leaf_entry = rdata_q;
        LEAF_BUILT: res_d.leaf_entry = leaf_word;
        default:    res_d.leaf_entry = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= table_mem[slot];
    if (wr_en) begin
      table_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    lvl_q  <= lvl_d;
    page_q <= page_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_used_q <= '0;
      page_limit_q <= PAGE_LIMIT_RESET;
      clr_cnt_q    <= '0;
    end else begin
      pages_used_q <= pages_used_d;
      page_limit_q <= page_limit_d;
      clr_cnt_q    <= clr_cnt_d;
    end
  end

  assign result_o = res_q;

endmodule

// ===== hw/rtl/ept_fault_table_builder.sv =====
`timescale 1ns / 1ps
// ept_fault_table_builder: top level, four-level translation table lookup and fault build
// depends on eftb_pkg, eftb_ctrl and eftb_datapath
//
//   port group              | dir | transfer on
//   start, req_i            | in  | start high and busy low at the clock edge
//   done_o, result_o        | out | done_o high for one cycle, always taken
//   cfg_we_i, cfg_wdata_i   | in  | cfg_we_i high at the clock edge (page_limit)
//
// each table level takes a memory read state, then an evaluate state that may write
// a full walk visits all four levels before done_o; early misses and exhaustion
// finish sooner, a fault with an access bit set finishes from the first read state
// after reset busy stays high while all table entries are zeroed
// a new request may be taken in the cycle done_o is shown; the receiver cannot stall

module ept_fault_table_builder #(
  parameter int unsigned POOL_PAGES = eftb_pkg::POOL_PAGES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  eftb_pkg::req_t                  req_i,
  output logic                            done_o,
  output eftb_pkg::result_t               result_o,
  input  logic                            cfg_we_i,
  input  logic [eftb_pkg::PAGE_CNT_W-1:0] cfg_wdata_i
);
  import eftb_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  eftb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .done_o (done_o)
  );

  eftb_datapath #(
    .POOL_PAGES (POOL_PAGES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .result_o    (result_o)
  );

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while a walk is still running");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted request did not start a walk");

  a_alloc_in_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.alloc |-> stat.alloc_ok && stat.entry_zero && !stat.last_level)
    else $error("page allocated outside the pool budget");

  a_built_is_leaf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status == ST_BUILT |->
      result_o.flush_request && result_o.leaf_entry[5:0] == LEAF_BITS[5:0])
    else $error("built mapping without leaf attributes or flush");

endmodule
